@@ sv/sstrk_pkg.sv @@
`timescale 1ns / 1ps

package sstrk_pkg;

   localparam int unsigned SEQ_W   = 64;
   localparam int unsigned CNT_W   = 64;
   localparam int unsigned NBYTE_W = 32;
   localparam int unsigned DIR_W   = 8;
   localparam int unsigned CSR_AW  = 4;
   localparam int unsigned CSR_DW  = 64;

   localparam logic [NBYTE_W-1:0] FRAME_LIMIT_RESET = 32'd65536;

   // register index is taken from address bit 3 (8-byte stride)
   localparam logic REG_BYTE_BUDGET = 1'b0;
   localparam logic REG_FRAME_LIMIT = 1'b1;

   localparam logic DIR_TX = 1'b0;
   localparam logic DIR_RX = 1'b1;

   typedef enum logic [1:0] {
      OP_DATA  = 2'd0,
      OP_HALF  = 2'd1,
      OP_CLOSE = 2'd2,
      OP_RSVD  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_STALE = 2'd1,
      ST_LARGE = 2'd2,
      ST_BAD   = 2'd3
   } status_type;

   typedef struct packed {
      op_type             op;
      logic [DIR_W-1:0]   direction;
      logic [SEQ_W-1:0]   sequence_req;
      logic [NBYTE_W-1:0] data_bytes;
      logic [SEQ_W-1:0]   close_tx_last_seq;
      logic [SEQ_W-1:0]   close_rx_last_seq;
      logic [CNT_W-1:0]   close_tx_bytes;
      logic [CNT_W-1:0]   close_rx_bytes;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [SEQ_W-1:0] tx_expected_seq;
      logic [SEQ_W-1:0] rx_expected_seq;
      logic [CNT_W-1:0] tx_byte_count;
      logic [CNT_W-1:0] rx_byte_count;
      logic             tx_half_shut;
      logic             rx_half_shut;
      logic             stream_shut;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0]   byte_budget;
      logic [NBYTE_W-1:0] frame_limit;
   } cfg_type;

endpackage

@@ sv/sstrk_if.sv @@
`timescale 1ns / 1ps

interface sstrk_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    op;
   logic [sstrk_pkg::DIR_W-1:0]   direction;
   logic [sstrk_pkg::SEQ_W-1:0]   sequence_req;
   logic [sstrk_pkg::NBYTE_W-1:0] data_bytes;
   logic [sstrk_pkg::SEQ_W-1:0]   close_tx_last_seq;
   logic [sstrk_pkg::SEQ_W-1:0]   close_rx_last_seq;
   logic [sstrk_pkg::CNT_W-1:0]   close_tx_bytes;
   logic [sstrk_pkg::CNT_W-1:0]   close_rx_bytes;

   modport source (
      output valid, op, direction, sequence_req, data_bytes,
             close_tx_last_seq, close_rx_last_seq, close_tx_bytes, close_rx_bytes,
      input  ready
   );
   modport sink (
      input  valid, op, direction, sequence_req, data_bytes,
             close_tx_last_seq, close_rx_last_seq, close_tx_bytes, close_rx_bytes,
      output ready
   );
endinterface

interface sstrk_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  status;
   logic [sstrk_pkg::SEQ_W-1:0] tx_expected_seq;
   logic [sstrk_pkg::SEQ_W-1:0] rx_expected_seq;
   logic [sstrk_pkg::CNT_W-1:0] tx_byte_count;
   logic [sstrk_pkg::CNT_W-1:0] rx_byte_count;
   logic                        tx_half_shut;
   logic                        rx_half_shut;
   logic                        stream_shut;

   modport source (
      output valid, status, tx_expected_seq, rx_expected_seq, tx_byte_count,
             rx_byte_count, tx_half_shut, rx_half_shut, stream_shut,
      input  ready
   );
   modport sink (
      input  valid, status, tx_expected_seq, rx_expected_seq, tx_byte_count,
             rx_byte_count, tx_half_shut, rx_half_shut, stream_shut,
      output ready
   );
endinterface

@@ sv/stream_sequence_byte_tracker_top.sv @@
`timescale 1ns / 1ps

// channel   | dir | handshake     | payload
// ----------+-----+---------------+-----------------------------------------
// req_chan  | in  | valid/ready   | op, direction, sequence, bytes, close claims
// rsp_chan  | out | valid/ready   | status, expected seqs, byte counts, flags
// csr_*     | in  | APB, pready=1 | byte_budget @0x0, frame_limit @0x8
//
// One transaction per cycle while rsp_chan is not stalled; rsp valid comes from the result register.
// Input register, then check/update logic against the stream state, then the
// result register. Sync active-high reset clears state and both valid flags.
// A stalled rsp holds the result register; one more transaction is taken into
// the input register meanwhile, then req_chan.ready drops.

module stream_sequence_byte_tracker_top (
   input  logic                           clock,
   input  logic                           reset,
   sstrk_req_if.sink                      req_chan,
   sstrk_rsp_if.source                    rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sstrk_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [sstrk_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [sstrk_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                           csr_pready
);

   logic               in_valid_ff, out_valid_ff;
   sstrk_pkg::req_type in_data_ff;
   sstrk_pkg::rsp_type out_data_ff, eng_rsp;
   sstrk_pkg::cfg_type cfg_ff;
   logic               advance, csr_wr;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (!out_valid_ff || rsp_chan.ready) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_data_ff.op                <= sstrk_pkg::op_type'(req_chan.op);
         in_data_ff.direction         <= req_chan.direction;
         in_data_ff.sequence_req      <= req_chan.sequence_req;
         in_data_ff.data_bytes        <= req_chan.data_bytes;
         in_data_ff.close_tx_last_seq <= req_chan.close_tx_last_seq;
         in_data_ff.close_rx_last_seq <= req_chan.close_rx_last_seq;
         in_data_ff.close_tx_bytes    <= req_chan.close_tx_bytes;
         in_data_ff.close_rx_bytes    <= req_chan.close_rx_bytes;
      end
      if (advance) begin
         out_data_ff <= eng_rsp;
      end
   end

   sstrk_engine u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (in_data_ff),
      .cfg   (cfg_ff),
      .rsp   (eng_rsp)
   );

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.byte_budget <= '0;
         cfg_ff.frame_limit <= sstrk_pkg::FRAME_LIMIT_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[3])
            sstrk_pkg::REG_BYTE_BUDGET: cfg_ff.byte_budget <= csr_pwdata;
            sstrk_pkg::REG_FRAME_LIMIT:
               cfg_ff.frame_limit <= csr_pwdata[sstrk_pkg::NBYTE_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3])
         sstrk_pkg::REG_BYTE_BUDGET: csr_prdata = cfg_ff.byte_budget;
         sstrk_pkg::REG_FRAME_LIMIT:
            csr_prdata = {{(sstrk_pkg::CSR_DW-sstrk_pkg::NBYTE_W){1'b0}},
                          cfg_ff.frame_limit};
      endcase
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.status          = out_data_ff.status;
   assign rsp_chan.tx_expected_seq = out_data_ff.tx_expected_seq;
   assign rsp_chan.rx_expected_seq = out_data_ff.rx_expected_seq;
   assign rsp_chan.tx_byte_count   = out_data_ff.tx_byte_count;
   assign rsp_chan.rx_byte_count   = out_data_ff.rx_byte_count;
   assign rsp_chan.tx_half_shut    = out_data_ff.tx_half_shut;
   assign rsp_chan.rx_half_shut    = out_data_ff.rx_half_shut;
   assign rsp_chan.stream_shut     = out_data_ff.stream_shut;

endmodule

@@ sv/sstrk_engine.sv @@
`timescale 1ns / 1ps

module sstrk_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  sstrk_pkg::req_type req,
   input  sstrk_pkg::cfg_type cfg,
   output sstrk_pkg::rsp_type rsp
);

   logic [sstrk_pkg::SEQ_W-1:0] tx_seq_ff, tx_seq_in, rx_seq_ff, rx_seq_in;
   logic [sstrk_pkg::CNT_W-1:0] tx_cnt_ff, tx_cnt_in, rx_cnt_ff, rx_cnt_in;
   logic [sstrk_pkg::CNT_W:0]   total_ff, total_in;   // tx + rx, exact
   logic                        tx_half_ff, tx_half_in, rx_half_ff, rx_half_in;
   logic                        shut_ff, shut_in;

   logic                          dir_ok, d;
   logic [sstrk_pkg::SEQ_W-1:0]   exp_d, last_d, tx_last, rx_last;
   logic [sstrk_pkg::CNT_W-1:0]   cnt_d;
   logic                          half_d;
   logic [sstrk_pkg::CNT_W:0]     d_sum;
   logic [sstrk_pkg::CNT_W+1:0]   t_sum;
   logic                          too_large;
   sstrk_pkg::status_type         status;

   always_comb begin
      dir_ok  = (req.direction[sstrk_pkg::DIR_W-1:1] == '0);
      d       = req.direction[0];
      exp_d   = (d == sstrk_pkg::DIR_RX) ? rx_seq_ff : tx_seq_ff;
      cnt_d   = (d == sstrk_pkg::DIR_RX) ? rx_cnt_ff : tx_cnt_ff;
      half_d  = (d == sstrk_pkg::DIR_RX) ? rx_half_ff : tx_half_ff;
      tx_last = (tx_seq_ff == '0) ? '0 : tx_seq_ff - 64'd1;
      rx_last = (rx_seq_ff == '0) ? '0 : rx_seq_ff - 64'd1;
      last_d  = (d == sstrk_pkg::DIR_RX) ? rx_last : tx_last;
      d_sum   = {1'b0, cnt_d} + {{(sstrk_pkg::CNT_W-sstrk_pkg::NBYTE_W+1){1'b0}},
                                 req.data_bytes};
      t_sum   = {1'b0, total_ff} + {{(sstrk_pkg::CNT_W-sstrk_pkg::NBYTE_W+2){1'b0}},
                                    req.data_bytes};
      too_large = (exp_d == '1) || (req.data_bytes > cfg.frame_limit) ||
                  d_sum[sstrk_pkg::CNT_W] || total_ff[sstrk_pkg::CNT_W] ||
                  (t_sum[sstrk_pkg::CNT_W+1:sstrk_pkg::CNT_W] != 2'b00) ||
                  ((cfg.byte_budget != '0) &&
                   (t_sum[sstrk_pkg::CNT_W-1:0] > cfg.byte_budget));

      unique case (req.op)
         sstrk_pkg::OP_DATA: begin
            if (shut_ff || !dir_ok || req.sequence_req != exp_d || half_d) begin
               status = sstrk_pkg::ST_STALE;
            end else if (too_large) begin
               status = sstrk_pkg::ST_LARGE;
            end else begin
               status = sstrk_pkg::ST_OK;
            end
         end
         sstrk_pkg::OP_HALF: begin
            if (shut_ff || !dir_ok || half_d || req.sequence_req != last_d) begin
               status = sstrk_pkg::ST_STALE;
            end else begin
               status = sstrk_pkg::ST_OK;
            end
         end
         sstrk_pkg::OP_CLOSE: begin
            if (shut_ff) begin
               status = sstrk_pkg::ST_STALE;
            end else if (req.close_tx_last_seq != tx_last ||
                         req.close_rx_last_seq != rx_last ||
                         req.close_tx_bytes != tx_cnt_ff ||
                         req.close_rx_bytes != rx_cnt_ff) begin
               status = sstrk_pkg::ST_BAD;
            end else begin
               status = sstrk_pkg::ST_OK;
            end
         end
         sstrk_pkg::OP_RSVD: begin
            status = sstrk_pkg::ST_BAD;
         end
      endcase
   end

   always_comb begin
      tx_seq_in  = tx_seq_ff;
      rx_seq_in  = rx_seq_ff;
      tx_cnt_in  = tx_cnt_ff;
      rx_cnt_in  = rx_cnt_ff;
      total_in   = total_ff;
      tx_half_in = tx_half_ff;
      rx_half_in = rx_half_ff;
      shut_in    = shut_ff;
      if (status == sstrk_pkg::ST_OK) begin
         unique case (req.op)
            sstrk_pkg::OP_DATA: begin
               total_in = t_sum[sstrk_pkg::CNT_W:0];
               if (d == sstrk_pkg::DIR_RX) begin
                  rx_seq_in = rx_seq_ff + 64'd1;
                  rx_cnt_in = d_sum[sstrk_pkg::CNT_W-1:0];
               end else begin
                  tx_seq_in = tx_seq_ff + 64'd1;
                  tx_cnt_in = d_sum[sstrk_pkg::CNT_W-1:0];
               end
            end
            sstrk_pkg::OP_HALF: begin
               if (d == sstrk_pkg::DIR_RX) begin
                  rx_half_in = 1'b1;
               end else begin
                  tx_half_in = 1'b1;
               end
            end
            sstrk_pkg::OP_CLOSE: begin
               shut_in = 1'b1;
            end
            sstrk_pkg::OP_RSVD: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_seq_ff  <= '0;
         rx_seq_ff  <= '0;
         tx_cnt_ff  <= '0;
         rx_cnt_ff  <= '0;
         total_ff   <= '0;
         tx_half_ff <= 1'b0;
         rx_half_ff <= 1'b0;
         shut_ff    <= 1'b0;
      end else if (fire) begin
         tx_seq_ff  <= tx_seq_in;
         rx_seq_ff  <= rx_seq_in;
         tx_cnt_ff  <= tx_cnt_in;
         rx_cnt_ff  <= rx_cnt_in;
         total_ff   <= total_in;
         tx_half_ff <= tx_half_in;
         rx_half_ff <= rx_half_in;
         shut_ff    <= shut_in;
      end
   end

   always_comb begin
      rsp.status          = status;
      rsp.tx_expected_seq = tx_seq_in;
      rsp.rx_expected_seq = rx_seq_in;
      rsp.tx_byte_count   = tx_cnt_in;
      rsp.rx_byte_count   = rx_cnt_in;
      rsp.tx_half_shut    = tx_half_in;
      rsp.rx_half_shut    = rx_half_in;
      rsp.stream_shut     = shut_in;
   end

endmodule

@@ sv/sstrk_checker.sv @@
`timescale 1ns / 1ps

module sstrk_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [1:0]                  rsp_status,
   input logic [sstrk_pkg::SEQ_W-1:0] rsp_tx_expected_seq,
   input logic                        rsp_stream_shut
);

   logic [1:0] pending_ff, pending_in;
   logic       shut_seen_ff, shut_seen_in;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      pending_in   = pending_ff + {1'b0, req_fire} - {1'b0, rsp_fire};
      shut_seen_in = shut_seen_ff || (rsp_fire && rsp_stream_shut);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         shut_seen_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         shut_seen_ff <= shut_seen_in;
      end
   end

   // at most the input and result registers are occupied
   a_pending_max: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two transactions in flight");

   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("rsp valid without a pending req");

   a_shut_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && shut_seen_ff) |-> rsp_stream_shut)
      else $error("stream reopened after full close");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_tx_expected_seq)))
      else $error("stalled rsp changed");

endmodule

bind stream_sequence_byte_tracker_top sstrk_checker u_sstrk_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_status          (rsp_chan.status),
   .rsp_tx_expected_seq (rsp_chan.tx_expected_seq),
   .rsp_stream_shut     (rsp_chan.stream_shut)
);
